// ===== sv/psl_pkg.sv =====
`default_nettype none

package psl_pkg;

  localparam int unsigned CFG_INDEX_W = 3;
  localparam int unsigned CFG_DATA_W  = 16;

  localparam logic [CFG_INDEX_W-1:0] REG_GAIN_P           = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_GAIN_I           = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_GAIN_D           = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_SEPARATION_LIMIT = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_INTEGRAL_BOUND   = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_OUTPUT_BOUND     = 3'd5;

  localparam int unsigned Q_FRAC = 8;

  typedef struct packed {
    logic signed [15:0] gain_p;
    logic signed [15:0] gain_i;
    logic signed [15:0] gain_d;
    logic        [15:0] separation_limit;
    logic        [14:0] integral_bound;
    logic        [14:0] output_bound;
  } cfg_t;

  // Gain terms handed from the error stage to the output stage
  typedef struct packed {
    logic signed [32:0] p_term;
    logic signed [31:0] i_term;
    logic signed [33:0] d_term;
  } terms_t;

endpackage

`default_nettype wire

// ===== sv/psl_front.sv =====
`default_nettype none

module psl_front (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               load,
  input  wire logic signed [15:0] target_speed,
  input  wire logic signed [15:0] measured_speed,
  input  wire psl_pkg::cfg_t      cfg,
  output psl_pkg::terms_t         terms
);
  import psl_pkg::*;

  logic signed [16:0] prior_error;
  logic signed [15:0] integral_sum;

  logic signed [16:0] err;
  logic        [16:0] mag;
  logic signed [17:0] integral_wide;
  logic signed [17:0] err_wide;
  logic signed [17:0] integral_pre;
  logic signed [17:0] bound_wide;
  logic signed [17:0] integral_clamped;
  logic signed [15:0] integral_sum_next;
  logic signed [17:0] err_diff;
  logic signed [17:0] prior_wide;
  terms_t             terms_next;

  always_comb begin
    err = {target_speed[15], target_speed} - {measured_speed[15], measured_speed};
    mag = err[16] ? 17'(-err) : 17'(err);

    integral_wide = {{2{integral_sum[15]}}, integral_sum};
    err_wide      = {err[16], err};
    prior_wide    = {prior_error[16], prior_error};

    // Clear the integral once the error reaches the separation limit
    if (mag >= {1'b0, cfg.separation_limit}) begin
      integral_pre = '0;
    end else begin
      integral_pre = integral_wide + err_wide;
    end

    bound_wide = {3'b000, cfg.integral_bound};
    if (integral_pre >= bound_wide) begin
      integral_clamped = bound_wide;
    end else if (integral_pre <= -bound_wide) begin
      integral_clamped = -bound_wide;
    end else begin
      integral_clamped = integral_pre;
    end
    integral_sum_next = integral_clamped[15:0];

    err_diff = err_wide - prior_wide;

    terms_next.p_term = cfg.gain_p * err;
    terms_next.i_term = cfg.gain_i * integral_sum_next;
    terms_next.d_term = cfg.gain_d * err_diff;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prior_error  <= '0;
      integral_sum <= '0;
    end else if (load) begin
      prior_error  <= err;
      integral_sum <= integral_sum_next;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      terms <= terms_next;
    end
  end

endmodule

`default_nettype wire

// ===== sv/psl_back.sv =====
`default_nettype none

module psl_back (
  input  wire logic               clk,
  input  wire logic               load,
  input  wire psl_pkg::terms_t    terms,
  input  wire logic        [14:0] output_bound,
  output logic signed      [15:0] drive
);
  import psl_pkg::*;

  logic signed [35:0] acc;
  logic signed [35:0] acc_adj;
  logic signed [27:0] quot;
  logic signed [27:0] bound_wide;
  logic signed [27:0] quot_clamped;

  always_comb begin
    acc = 36'(terms.p_term) + 36'(terms.i_term) + 36'(terms.d_term);
    // Bias negative sums so the shift truncates toward zero
    acc_adj = acc[35] ? acc + 36'((1 << Q_FRAC) - 1) : acc;
    quot    = 28'(acc_adj >>> Q_FRAC);

    bound_wide = {13'd0, output_bound};
    if (quot >= bound_wide) begin
      quot_clamped = bound_wide;
    end else if (quot <= -bound_wide) begin
      quot_clamped = -bound_wide;
    end else begin
      quot_clamped = quot;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      drive <= quot_clamped[15:0];
    end
  end

endmodule

`default_nettype wire

// ===== sv/pid_speed_loop_integral_separation.sv =====
// Speed-loop PID controller with integral separation and clamping.
//
// Input channel: in_valid / in_stall carry one request of target_speed and
// measured_speed. Output channel: out_valid / out_stall carry one drive value
// per request, in request order. A request is taken at a rising edge with
// valid high and stall low.
// From acceptance to out_valid, the request lands in an input register, the
// error/integral stage and its three gain multiplies feed the terms register,
// and the sum, truncation and clamp feed the output register.
// One request is taken every cycle while in_stall is low; the integral and
// previous error update in the same cycle a request enters the terms register,
// so consecutive requests see each other's state.
// When the receiver stalls, the output register holds its value and empty
// stages ahead of it still fill, so up to three requests are held before
// in_stall rises.
// Configuration is a plain write port (cfg_write_enable, cfg_index, cfg_data)
// and must be written only while no request is in flight; unknown indexes are
// ignored. Synchronous reset clears the pipeline valid flags, the integral and the
// previous error, and loads the register reset values.
`default_nettype none

module pid_speed_loop_integral_separation (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                in_valid,
  output logic                                     in_stall,
  input  wire logic signed [15:0]                  target_speed,
  input  wire logic signed [15:0]                  measured_speed,
  output logic                                     out_valid,
  input  wire logic                                out_stall,
  output logic signed [15:0]                       drive,
  input  wire logic                                cfg_write_enable,
  input  wire logic        [psl_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic        [psl_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import psl_pkg::*;

  cfg_t               cfg;
  logic               valid_a;
  logic               valid_b;
  logic signed [15:0] target_a;
  logic signed [15:0] measured_a;
  logic               load_a;
  logic               load_b;
  logic               load_c;
  terms_t             terms_b;

  always_comb begin
    load_c   = !out_valid || !out_stall;
    load_b   = !valid_b || load_c;
    load_a   = !valid_a || load_b;
    in_stall = !load_a;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.gain_p           <= '0;
      cfg.gain_i           <= '0;
      cfg.gain_d           <= '0;
      cfg.separation_limit <= 16'hFFFF;
      cfg.integral_bound   <= 15'h7FFF;
      cfg.output_bound     <= 15'h7FFF;
    end else if (cfg_write_enable) begin
      unique case (cfg_index)
        REG_GAIN_P:           cfg.gain_p           <= cfg_data;
        REG_GAIN_I:           cfg.gain_i           <= cfg_data;
        REG_GAIN_D:           cfg.gain_d           <= cfg_data;
        REG_SEPARATION_LIMIT: cfg.separation_limit <= cfg_data;
        REG_INTEGRAL_BOUND:   cfg.integral_bound   <= cfg_data[14:0];
        REG_OUTPUT_BOUND:     cfg.output_bound     <= cfg_data[14:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_a   <= 1'b0;
      valid_b   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (load_a) begin
        valid_a <= in_valid;
      end
      if (load_b) begin
        valid_b <= valid_a;
      end
      if (load_c) begin
        out_valid <= valid_b;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_a) begin
      target_a   <= target_speed;
      measured_a <= measured_speed;
    end
  end

  psl_front u_front (
    .clk            (clk),
    .rst            (rst),
    .load           (load_b && valid_a),
    .target_speed   (target_a),
    .measured_speed (measured_a),
    .cfg            (cfg),
    .terms          (terms_b)
  );

  psl_back u_back (
    .clk          (clk),
    .load         (load_c && valid_b),
    .terms        (terms_b),
    .output_bound (cfg.output_bound),
    .drive        (drive)
  );

endmodule

`default_nettype wire
